// File: design/csa_pkg.sv
// Package for the categorical sampler / argmax block.
// Holds field widths, saturation limits and the input transaction type.
// No dependencies.
package csa_pkg;

    localparam int SCORE_W = 24;
    localparam int THR_W   = 16;
    localparam int IDX_W   = 11;
    localparam int SUM_W   = 34;
    localparam int DIM_DEF = 1024;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [IDX_W-1:0] IDX_NONE = '1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_ARGMAX = 1'b1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [THR_W-1:0]          threshold;
        logic                      row_end;
    } t_item;

endpackage

// File: design/csa_row_state.sv
// Row state of the categorical sampler: running sum, threshold hit and argmax.
// Updates once per advanced transaction and presents the row result.
// Depends on csa_pkg.
module csa_row_state
    import csa_pkg::*;
#(
    parameter int DIM = DIM_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  t_item                   i_item,
    input  logic                    i_mode,
    output logic signed [IDX_W-1:0] o_chosen_index
);

    localparam int PW = $clog2(DIM + 1);
    localparam logic [PW-1:0] POS_LIMIT = PW'(DIM);

    logic [PW-1:0]             r_pos, n_pos;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [THR_W-1:0]          r_thr, n_thr;
    logic                      r_hit, n_hit;
    logic signed [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic signed [SCORE_W-1:0] r_best, n_best;
    logic signed [IDX_W-1:0]   r_best_idx, n_best_idx;

    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic [THR_W-1:0]          thr_eff;
    logic signed [IDX_W-1:0]   cur_idx;

    always_comb begin
        thr_eff  = (r_pos == '0) ? i_item.threshold : r_thr;
        cur_idx  = IDX_W'(r_pos);
        sum_wide = {r_sum[SUM_W-1], r_sum} + (SUM_W+1)'(i_item.score);
        // Clamp to the 34-bit signed range when the add overflows.
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_sat = sum_wide[SUM_W-1:0];
        end

        n_pos      = r_pos;
        n_sum      = r_sum;
        n_thr      = thr_eff;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_best     = r_best;
        n_best_idx = r_best_idx;

        if (r_pos < POS_LIMIT) begin
            n_pos = r_pos + PW'(1);
            n_sum = sum_sat;
            if (!r_hit && (sum_sat >= $signed({{(SUM_W-THR_W){1'b0}}, thr_eff}))) begin
                n_hit     = 1'b1;
                n_hit_idx = cur_idx;
            end
            // The first element of a row always becomes the candidate.
            if ((r_pos == '0) || (i_item.score > r_best)) begin
                n_best     = i_item.score;
                n_best_idx = cur_idx;
            end
        end

        if (i_mode == MODE_SAMPLE) begin
            o_chosen_index = n_hit ? n_hit_idx : IDX_NONE;
        end else begin
            o_chosen_index = n_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_thr      <= '0;
            r_hit      <= 1'b0;
            r_hit_idx  <= IDX_NONE;
            r_best     <= SCORE_MIN;
            r_best_idx <= IDX_NONE;
        end else if (i_advance) begin
            if (i_item.row_end) begin
                r_pos      <= '0;
                r_sum      <= '0;
                r_thr      <= '0;
                r_hit      <= 1'b0;
                r_hit_idx  <= IDX_NONE;
                r_best     <= SCORE_MIN;
                r_best_idx <= IDX_NONE;
            end else begin
                r_pos      <= n_pos;
                r_sum      <= n_sum;
                r_thr      <= n_thr;
                r_hit      <= n_hit;
                r_hit_idx  <= n_hit_idx;
                r_best     <= n_best;
                r_best_idx <= n_best_idx;
            end
        end
    end

endmodule

// File: design/categorical_sample_or_argmax.sv
// Categorical sampler / argmax over streamed rows of class scores.
// Throughput: one element transaction per cycle, set by the single saturating add and compare, unless a
// row_end element waits while an untaken result is held. A row_end element is captured in the input
// register and, once it advances, loads the result register, from which the downstream side takes it.
// Reset (i_rst_n, synchronous, active low) empties both registers, clears the row
// state and selects argmax mode.
module categorical_sample_or_argmax
    import csa_pkg::*;
#(
    parameter int DIM = DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration: mode register, 0 samples by threshold, 1 takes argmax.
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_wdata,
    // Element input channel.
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [THR_W-1:0]          i_threshold,
    input  logic                      i_row_end,
    // Result channel, one transaction per row.
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [IDX_W-1:0]   o_chosen_index
);

    logic                    r_mode;
    logic                    r_in_valid;
    t_item                   r_in_item;
    logic                    r_out_valid;
    logic signed [IDX_W-1:0] r_out_index;

    logic                    advance;
    logic signed [IDX_W-1:0] row_result;

    // The held element moves into the row state unless it closes a row while
    // the result register is still occupied by an untaken result. Elements that
    // do not close a row never wait on the output side.
    assign advance    = r_in_valid && (!r_in_item.row_end || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ARGMAX;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // Input register: captures every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= '{score: i_score, threshold: i_threshold, row_end: i_row_end};
        end
    end

    csa_row_state #(
        .DIM (DIM)
    ) u_row_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_item         (r_in_item),
        .i_mode         (r_mode),
        .o_chosen_index (row_result)
    );

    // Result register: loaded when a row-closing element advances; it holds
    // until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_item.row_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_item.row_end) begin
            r_out_index <= row_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_out_index;

endmodule

// File: design/csa_checker.sv
// Port-level checks for categorical_sample_or_argmax, attached by bind.
// Depends on csa_pkg and the top level's port list.
module csa_checker
    import csa_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      i_row_end,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [IDX_W-1:0]   o_chosen_index
);

    // A stalled result transaction stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_chosen_index))
        else $error("result changed or dropped while stalled");

    // With the result register empty nothing can block the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // A row-closing transaction produces a result once it has passed the input register into the result register.
    a_row_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_row_end |=> ##1 o_out_valid)
        else $error("no result after row end");

    // Leaving reset, no result is offered.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result offered out of reset");

endmodule

bind categorical_sample_or_argmax csa_checker u_csa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_row_end      (i_row_end),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_chosen_index (o_chosen_index)
);
